// File: design/drum_sample_mixer_top_defines.svh
// assertion macros for the drum sample mixer checker
// depends on a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef DRUM_SAMPLE_MIXER_TOP_DEFINES_SVH
`define DRUM_SAMPLE_MIXER_TOP_DEFINES_SVH

// property checked only while out of reset
`define DSM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// property checked on every edge, reset included
`define DSM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/dsm_pkg.sv
// shared types and constants of the drum sample mixer
// no dependencies
package dsm_pkg;

    localparam int KIND_W    = 2;
    localparam int DRUM_W    = 3;
    localparam int INDEX_W   = 14;
    localparam int SAMPLE_W  = 16;
    localparam int MIX_W     = 19;
    localparam int POS_W     = 15;
    localparam int LEN_W     = 15;
    localparam int GAIN_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int LEN_REGS  = 7;
    localparam int LEN_IDX_W = 3;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // input kind codes
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIGGER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT = 3'd7;

    localparam logic [GAIN_W-1:0]     GAIN_RESET = 2'd1;
    localparam logic signed [16:0]    PCM_BIAS   = 17'sd32768;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_TRIGGER,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [DRUM_W-1:0]    drum;
        logic [INDEX_W-1:0]   index;
        logic [SAMPLE_W-1:0]  value;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DRAIN
    } t_state;

endpackage

// File: design/drum_sample_mixer_top.sv
// tick: the sequencer leaves idle for the tick state, which walks the voices, then the
// drain state, which pushes the mix into the result queue that drives the ports
// trigger and load: each handled in the idle state of the sequencer, one memory write port
// tick rate is set by at most one sample memory read per voice, one voice a cycle
// reset (synchronous, active low) empties both queues, stops all voices,
// clears lengths to 0 and sets gain shift to 1; sample memory is not cleared
module drum_sample_mixer_top #(
    parameter int VOICE_COUNT  = 7,
    parameter int SAMPLE_DEPTH = 16384
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input queue side
    input  logic                                push,
    output logic                                full,
    input  logic [dsm_pkg::KIND_W-1:0]          i_kind,
    input  logic [dsm_pkg::DRUM_W-1:0]          i_drum,
    input  logic [dsm_pkg::INDEX_W-1:0]         i_sample_index,
    input  logic [dsm_pkg::SAMPLE_W-1:0]        i_sample_value,
    // result queue side
    output logic                                empty,
    input  logic                                pop,
    output logic signed [dsm_pkg::MIX_W-1:0]    o_mix,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dsm_pkg::LEN_W-1:0]           i_cfg_data
);

    import dsm_pkg::*;

    // command queue between front and back
    logic                cmd_valid;
    t_cmd                cmd;
    logic                cmd_pop;

    // result queue signals
    logic                res_push;
    logic                res_full;
    logic signed [MIX_W-1:0] res_mix;
    logic [MIX_W-1:0]    res_head;

    // front: classifies transactions, drops ignored kinds, out-of-range voices and load indexes
    dsm_front #(
        .VOICE_COUNT  (VOICE_COUNT),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_drum         (i_drum),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    // back: voice state, sample memory, mix sequencer
    // a tick only starts once the result queue has a free slot
    dsm_back #(
        .VOICE_COUNT  (VOICE_COUNT),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res_mix   (res_mix)
    );

    // result queue decouples the sequencer from the consumer
    dsm_fifo #(
        .WIDTH (MIX_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_mix),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_mix = res_head;

endmodule

// File: design/dsm_fifo.sv
// small synchronous queue with full and empty flags
// no dependencies
module dsm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: design/dsm_front.sv
// front end: accepts input transactions, drops ignored ones, queues commands
// depends on dsm_pkg and dsm_fifo
module dsm_front #(
    parameter int VOICE_COUNT  = 7,
    parameter int SAMPLE_DEPTH = 16384
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [dsm_pkg::KIND_W-1:0]    i_kind,
    input  logic [dsm_pkg::DRUM_W-1:0]    i_drum,
    input  logic [dsm_pkg::INDEX_W-1:0]   i_sample_index,
    input  logic [dsm_pkg::SAMPLE_W-1:0]  i_sample_value,
    output logic                          o_cmd_valid,
    output dsm_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_pop
);

    import dsm_pkg::*;

    t_cmd                 cmd;
    logic                 keep;
    logic                 drum_ok;
    logic                 index_ok;
    logic                 cmd_empty;
    logic [$bits(t_cmd)-1:0] head;

    assign drum_ok  = (int'(i_drum) < VOICE_COUNT);
    assign index_ok = (int'(i_sample_index) < SAMPLE_DEPTH);

    always_comb begin
        cmd.drum  = i_drum;
        cmd.index = i_sample_index;
        cmd.value = i_sample_value;
        cmd.op    = OP_TICK;
        keep      = 1'b0;
        unique case (i_kind)
            KIND_TICK: begin
                keep = 1'b1;
            end
            KIND_TRIGGER: begin
                cmd.op = OP_TRIGGER;
                keep   = drum_ok;
            end
            KIND_LOAD: begin
                cmd.op = OP_LOAD;
                keep   = drum_ok && index_ok;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    dsm_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full && keep),
        .i_data  (cmd),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_data  (head),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;
    assign o_cmd       = t_cmd'(head);

endmodule

// File: design/dsm_back.sv
// back end: config registers, voice state, sample memory and tick sequencer
// depends on dsm_pkg
module dsm_back #(
    parameter int VOICE_COUNT  = 7,
    parameter int SAMPLE_DEPTH = 16384
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dsm_pkg::LEN_W-1:0]           i_cfg_data,
    input  logic                                i_cmd_valid,
    input  dsm_pkg::t_cmd                       i_cmd,
    output logic                                o_cmd_pop,
    input  logic                                i_res_full,
    output logic                                o_res_push,
    output logic signed [dsm_pkg::MIX_W-1:0]    o_res_mix
);

    import dsm_pkg::*;

    localparam int VW        = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int MEM_DEPTH = VOICE_COUNT * SAMPLE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    logic [LEN_W-1:0]    r_len [LEN_REGS];
    logic [GAIN_W-1:0]   r_gain;
    logic [POS_W-1:0]    r_pos [VOICE_COUNT];
    logic                r_active [VOICE_COUNT];
    t_state              r_state;
    t_state              n_state;
    logic [VW-1:0]       r_voice;
    logic signed [MIX_W-1:0] r_sum;
    logic                r_add;
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [SAMPLE_W-1:0] r_mem [MEM_DEPTH];

    logic                mem_we;
    logic                trig;
    logic                issue;
    logic                start;
    logic                rd_en;
    logic [VW-1:0]       cmd_voice;
    logic [POS_W-1:0]    cur_pos;
    logic [POS_W-1:0]    next_pos;
    logic [LEN_W-1:0]    cur_len;
    logic                stop;
    logic                in_region;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic signed [16:0]  diff;
    logic signed [16:0]  term;
    logic signed [MIX_W-1:0] acc;

    // voice lookup for the voice being walked
    assign cmd_voice = VW'(i_cmd.drum);
    assign cur_pos   = r_pos[r_voice];
    assign cur_len   = (int'(r_voice) < LEN_REGS) ? r_len[LEN_IDX_W'(r_voice)] : '0;
    assign next_pos  = cur_pos + 1'b1;
    assign stop      = (next_pos >= cur_len);
    assign in_region = (18'(cur_pos) < 18'(SAMPLE_DEPTH));
    assign rd_en     = issue && r_active[r_voice] && in_region;

    assign wr_addr = ADDR_W'(int'(cmd_voice) * SAMPLE_DEPTH) + ADDR_W'(i_cmd.index);
    assign rd_addr = ADDR_W'(int'(r_voice) * SAMPLE_DEPTH) + ADDR_W'(cur_pos);

    // remove bias then floor-shift by the gain
    assign diff = $signed({1'b0, r_rd_data}) - PCM_BIAS;
    assign term = diff >>> r_gain;
    assign acc  = r_add ? (r_sum + {{(MIX_W-17){term[16]}}, term}) : r_sum;

    assign o_res_mix = acc;

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        mem_we     = 1'b0;
        trig       = 1'b0;
        issue      = 1'b0;
        start      = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_TICK: begin
                            if (!i_res_full) begin
                                o_cmd_pop = 1'b1;
                                start     = 1'b1;
                                n_state   = ST_TICK;
                            end
                        end
                        OP_TRIGGER: begin
                            o_cmd_pop = 1'b1;
                            trig      = 1'b1;
                        end
                        OP_LOAD: begin
                            o_cmd_pop = 1'b1;
                            mem_we    = 1'b1;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                issue = 1'b1;
                if (r_voice == VW'(VOICE_COUNT - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_res_push = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_gain  <= GAIN_RESET;
            r_voice <= '0;
            r_add   <= 1'b0;
            for (int i = 0; i < LEN_REGS; i++) begin
                r_len[i] <= '0;
            end
            for (int v = 0; v < VOICE_COUNT; v++) begin
                r_pos[v]    <= '0;
                r_active[v] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (int'(i_cfg_idx) < LEN_REGS) begin
                    r_len[LEN_IDX_W'(i_cfg_idx)] <= i_cfg_data;
                end else if (i_cfg_idx == CFG_GAIN_SHIFT) begin
                    r_gain <= i_cfg_data[GAIN_W-1:0];
                end
            end
            if (trig) begin
                r_pos[cmd_voice]    <= '0;
                r_active[cmd_voice] <= 1'b1;
            end
            if (start) begin
                r_voice <= '0;
                r_add   <= 1'b0;
            end
            if (issue) begin
                r_add <= rd_en;
                if (r_active[r_voice]) begin
                    r_pos[r_voice] <= stop ? '0 : next_pos;
                    if (stop) begin
                        r_active[r_voice] <= 1'b0;
                    end
                end
                if (r_voice != VW'(VOICE_COUNT - 1)) begin
                    r_voice <= r_voice + 1'b1;
                end
            end
        end
    end

    // running sum
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_sum <= '0;
        end else if (issue) begin
            r_sum <= acc;
        end
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_cmd.value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

// File: design/dsm_checker.sv
// port-level checks on the drum sample mixer, bound to the top level
// depends on dsm_pkg and drum_sample_mixer_top_defines.svh
`include "drum_sample_mixer_top_defines.svh"

module dsm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             push,
    input logic                             full,
    input logic                             empty,
    input logic                             pop,
    input logic signed [dsm_pkg::MIX_W-1:0] o_mix
);

    // reset leaves both queues empty
    `DSM_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (empty && !full), "queues not cleared by reset")

    // the command queue fills only from accepted transactions
    `DSM_ASSERT(a_full_needs_push, $rose(full) |-> $past(push), "input full without a push")

    // a mix passes through the command queue and the sequencer, so none shows right after reset
    `DSM_ASSERT(a_no_early_result, $fell(empty) |-> ($past(i_rst_n, 1) && $past(i_rst_n, 2)), "result too soon after reset")

    // a waiting result holds until taken
    `DSM_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(o_mix)), "waiting result changed")

endmodule

bind drum_sample_mixer_top dsm_checker u_dsm_checker (.*);
